>>> rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/iirl_pkg.sv
`default_nettype none

package iirl_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int DATA_W       = 32;
  localparam int POS_W        = 6;
  localparam int OP_W         = 2;
  localparam int STAT_W       = 2;
  localparam int CNT_OUT_W    = 7;

  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
  localparam logic [OP_W-1:0] OP_READ   = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

endpackage

`default_nettype wire

>>> rtl/iirl_mem.sv
`default_nettype none

module iirl_mem #(
  parameter int DEPTH = iirl_pkg::CAPACITY_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                               clk,
  input  logic                               we,
  input  logic [AW-1:0]                      waddr,
  input  logic signed [iirl_pkg::DATA_W-1:0] wdata,
  input  logic [AW-1:0]                      raddr,
  output logic signed [iirl_pkg::DATA_W-1:0] rdata
);
  import iirl_pkg::*;

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> rtl/indexed_insert_remove_list.sv
// channel  | ports                                    | direction
// in       | in_valid in_ready in_opcode in_position  | into block
//          | in_value                                 |
// out      | out_valid out_ready out_read_value       | out of block
//          | out_status out_count                     |
// steps (idle to result): failed op goes to the result, append writes, read fetches,
//   insert shifts up from position then writes, remove fetches then shifts down;
//   each shifted entry costs one read and one write of the single-port-pair memory
// synchronous active-low reset clears the entry count and control state
// in_ready is high only in idle; a result waiting on out_ready holds the next
//   transaction in its final step
`default_nettype none

module indexed_insert_remove_list #(
  parameter int CAPACITY = iirl_pkg::CAPACITY_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [iirl_pkg::OP_W-1:0]             in_opcode,
  input  logic [iirl_pkg::POS_W-1:0]            in_position,
  input  logic signed [iirl_pkg::DATA_W-1:0]    in_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [iirl_pkg::DATA_W-1:0]    out_read_value,
  output logic [iirl_pkg::STAT_W-1:0]           out_status,
  output logic [iirl_pkg::CNT_OUT_W-1:0]        out_count
);
  import iirl_pkg::*;

`include "assert_macros.svh"

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_FETCH   = 9'b000000010,
    S_CAPTURE = 9'b000000100,
    S_UP_RD   = 9'b000001000,
    S_UP_WR   = 9'b000010000,
    S_DN_RD   = 9'b000100000,
    S_DN_WR   = 9'b001000000,
    S_PUT     = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [OP_W-1:0] op_r, op_nxt;
  logic signed [DATA_W-1:0] val_r, val_nxt;
  logic signed [DATA_W-1:0] rd_r, rd_nxt;
  logic [STAT_W-1:0] stat_r, stat_nxt;

  logic out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_rd_r, out_rd_nxt;
  logic [STAT_W-1:0] out_stat_r, out_stat_nxt;
  logic [CNT_OUT_W-1:0] out_cnt_r, out_cnt_nxt;

  logic mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic signed [DATA_W-1:0] mem_wdata, mem_rdata;

  logic [CW-1:0] k_dec, k_inc;
  logic [CMPW-1:0] pos_ext, cnt_ext;
  logic full;

  assign k_dec   = k_r - CW'(1);
  assign k_inc   = k_r + CW'(1);
  assign pos_ext = CMPW'(in_position);
  assign cnt_ext = CMPW'(count_r);
  assign full    = (count_r == CW'(CAPACITY));

  iirl_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    k_nxt         = k_r;
    pos_nxt       = pos_r;
    op_nxt        = op_r;
    val_nxt       = val_r;
    rd_nxt        = rd_r;
    stat_nxt      = stat_r;
    out_valid_nxt = out_valid_r;
    out_rd_nxt    = out_rd_r;
    out_stat_nxt  = out_stat_r;
    out_cnt_nxt   = out_cnt_r;
    mem_we        = 1'b0;
    mem_waddr     = k_r[AW-1:0];
    mem_wdata     = mem_rdata;
    mem_raddr     = k_r[AW-1:0];

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt   = in_opcode;
          pos_nxt  = CW'(in_position);
          val_nxt  = in_value;
          rd_nxt   = '0;
          stat_nxt = ST_OK;
          k_nxt    = count_r;
          unique case (in_opcode)
            OP_APPEND: begin
              if (full) begin
                stat_nxt  = ST_FULL;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_PUT;
              end
            end
            OP_INSERT: begin
              if (full) begin
                stat_nxt  = ST_FULL;
                state_nxt = S_DONE;
              end else if (pos_ext > cnt_ext) begin
                stat_nxt  = ST_RANGE;
                state_nxt = S_DONE;
              end else if (pos_ext == cnt_ext) begin
                state_nxt = S_PUT;
              end else begin
                state_nxt = S_UP_RD;
              end
            end
            OP_REMOVE, OP_READ: begin
              if (pos_ext >= cnt_ext) begin
                stat_nxt  = ST_RANGE;
                state_nxt = S_DONE;
              end else begin
                k_nxt     = CW'(in_position);
                state_nxt = S_FETCH;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_FETCH: begin
        mem_raddr = k_r[AW-1:0];
        state_nxt = S_CAPTURE;
      end
      S_CAPTURE: begin
        rd_nxt = mem_rdata;
        if (op_r == OP_REMOVE) begin
          if (k_inc < count_r) begin
            state_nxt = S_DN_RD;
          end else begin
            count_nxt = count_r - CW'(1);
            state_nxt = S_DONE;
          end
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_UP_RD: begin
        mem_raddr = k_dec[AW-1:0];
        state_nxt = S_UP_WR;
      end
      S_UP_WR: begin
        mem_we    = 1'b1;
        mem_waddr = k_r[AW-1:0];
        mem_wdata = mem_rdata;
        k_nxt     = k_dec;
        state_nxt = (k_dec == pos_r) ? S_PUT : S_UP_RD;
      end
      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = k_r[AW-1:0];
        mem_wdata = val_r;
        count_nxt = count_r + CW'(1);
        state_nxt = S_DONE;
      end
      S_DN_RD: begin
        mem_raddr = k_inc[AW-1:0];
        state_nxt = S_DN_WR;
      end
      S_DN_WR: begin
        mem_we    = 1'b1;
        mem_waddr = k_r[AW-1:0];
        mem_wdata = mem_rdata;
        k_nxt     = k_inc;
        if ((k_inc + CW'(1)) < count_r) begin
          state_nxt = S_DN_RD;
        end else begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_rd_nxt    = rd_r;
          out_stat_nxt  = stat_r;
          out_cnt_nxt   = CNT_OUT_W'(count_r);
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    pos_r      <= pos_nxt;
    op_r       <= op_nxt;
    val_r      <= val_nxt;
    rd_r       <= rd_nxt;
    stat_r     <= stat_nxt;
    out_rd_r   <= out_rd_nxt;
    out_stat_r <= out_stat_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_read_value = out_rd_r;
  assign out_status     = out_stat_r;
  assign out_count      = out_cnt_r;

  `ASSERT_IMPL(a_count_cap, clk, rst_n, 1'b1, count_r <= CW'(CAPACITY))
  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  `ASSERT_IMPL(a_fail_reads_zero, clk, rst_n, out_valid_r && (out_stat_r != ST_OK),
               out_rd_r == '0)
  `ASSERT_IMPL(a_full_at_cap, clk, rst_n, out_valid_r && (out_stat_r == ST_FULL),
               out_cnt_r == CNT_OUT_W'(CAPACITY))

endmodule

`default_nettype wire
